// ===== rtl/core/rounded_rect_pixel_coverage_macros.svh =====
// ----------------------------------------------------------------------------
// Rounded rectangle pixel coverage: assertion macros
// Shared concurrent check forms, sampled on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef ROUNDED_RECT_PIXEL_COVERAGE_MACROS_SVH
`define ROUNDED_RECT_PIXEL_COVERAGE_MACROS_SVH

// Same-cycle implication
`define RRPC_ASSERT_IMP(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("rrpc: same-cycle check failed");

// Next-cycle implication
`define RRPC_ASSERT_NEXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("rrpc: next-cycle check failed");

// Implication after a fixed number of cycles
`define RRPC_ASSERT_LAT(lbl, cond, n, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> ##n (prop)) \
    else $error("rrpc: latency check failed");

`endif

// ===== rtl/core/rrpc_pkg.sv =====
// ----------------------------------------------------------------------------
// Rounded rectangle pixel coverage: package
// Fixed widths, register indexes and the control bundle passed between stages.
// ----------------------------------------------------------------------------
package rrpc_pkg;

  localparam int COORD_W     = 16;            // signed rectangle origin
  localparam int POS_W       = COORD_W + 1;   // absolute pixel position, signed
  localparam int FRAME_DIM_W = 13;            // frame width / height registers
  localparam int PITCH_W     = 16;
  localparam int ADDR_W      = 32;
  localparam int COLOR_W     = 32;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 2;
  localparam int ROW_OFF_W   = FRAME_DIM_W + PITCH_W;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_BASE   = 2'd0,
    CFG_PITCH  = 2'd1,
    CFG_WIDTH  = 2'd2,
    CFG_HEIGHT = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [ADDR_W-1:0]      base;
    logic [PITCH_W-1:0]     pitch;
    logic [FRAME_DIM_W-1:0] width;
    logic [FRAME_DIM_W-1:0] height;
  } frame_cfg_t;

  // Per-beat control carried down the pipeline
  typedef struct packed {
    logic valid;        // stage holds a beat
    logic keep;         // offset inside rectangle and pixel on screen
    logic corner_zone;  // pixel falls in one of the corner regions
  } stage_ctl_t;

endpackage

// ===== rtl/core/rrpc_geom.sv =====
// ----------------------------------------------------------------------------
// Rounded rectangle pixel coverage: geometry stage
// Clips the pixel, picks the corner region and forms the corner distances.
// ----------------------------------------------------------------------------
module rrpc_geom #(
  parameter int DIM_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic [rrpc_pkg::COORD_W-1:0]        left,
  input  logic [rrpc_pkg::COORD_W-1:0]        top,
  input  logic [DIM_BITS-1:0]                 width,
  input  logic [DIM_BITS-1:0]                 height,
  input  logic [DIM_BITS-2:0]                 radius,
  input  logic [DIM_BITS-1:0]                 col,
  input  logic [DIM_BITS-1:0]                 row,
  input  logic [rrpc_pkg::COLOR_W-1:0]        color,
  input  rrpc_pkg::frame_cfg_t                frame_cfg,
  output rrpc_pkg::stage_ctl_t                ctl,
  output logic [DIM_BITS-2:0]                 dx,
  output logic [DIM_BITS-2:0]                 dy,
  output logic [DIM_BITS-2:0]                 radius_q,
  output logic [rrpc_pkg::FRAME_DIM_W-1:0]    px,
  output logic [rrpc_pkg::FRAME_DIM_W-1:0]    py,
  output logic [rrpc_pkg::COLOR_W-1:0]        color_q
);

  localparam int SUM_W = DIM_BITS + 1;
  localparam int POS_W = rrpc_pkg::POS_W;

  logic [DIM_BITS-1:0]  r_ext;
  logic [SUM_W-1:0]     c_plus_r;
  logic [SUM_W-1:0]     q_plus_r;
  logic                 left_z;
  logic                 right_z;
  logic                 top_z;
  logic                 bottom_z;
  logic [DIM_BITS-1:0]  dx_left;
  logic [DIM_BITS-1:0]  dy_top;
  logic [SUM_W-1:0]     dx_right;
  logic [SUM_W-1:0]     dy_bottom;
  logic [DIM_BITS-2:0]  dx_next;
  logic [DIM_BITS-2:0]  dy_next;
  logic                 zone;
  logic [POS_W-1:0]     px_full;
  logic [POS_W-1:0]     py_full;
  logic                 in_rect;
  logic                 on_screen;
  rrpc_pkg::stage_ctl_t ctl_next;

  // Corner region membership; right compares c + r against w, bottom q + r against h
  assign r_ext    = DIM_BITS'(radius);
  assign c_plus_r = SUM_W'(col) + SUM_W'(radius);
  assign q_plus_r = SUM_W'(row) + SUM_W'(radius);
  assign left_z   = col < r_ext;
  assign top_z    = row < r_ext;
  assign right_z  = c_plus_r >= SUM_W'(width);
  assign bottom_z = q_plus_r >= SUM_W'(height);

  // Distances from the corner circle center; in range they lie in 1..r
  assign dx_left   = r_ext - col;
  assign dy_top    = r_ext - row;
  assign dx_right  = c_plus_r + SUM_W'(1) - SUM_W'(width);
  assign dy_bottom = q_plus_r + SUM_W'(1) - SUM_W'(height);

  // Pick the first matching region: top-left, top-right, bottom-left, bottom-right
  always_comb begin
    zone    = 1'b1;
    dx_next = dx_left[DIM_BITS-2:0];
    dy_next = dy_top[DIM_BITS-2:0];
    if (left_z && top_z) begin
      dx_next = dx_left[DIM_BITS-2:0];
      dy_next = dy_top[DIM_BITS-2:0];
    end else if (right_z && top_z) begin
      dx_next = dx_right[DIM_BITS-2:0];
      dy_next = dy_top[DIM_BITS-2:0];
    end else if (left_z && bottom_z) begin
      dx_next = dx_left[DIM_BITS-2:0];
      dy_next = dy_bottom[DIM_BITS-2:0];
    end else if (right_z && bottom_z) begin
      dx_next = dx_right[DIM_BITS-2:0];
      dy_next = dy_bottom[DIM_BITS-2:0];
    end else begin
      zone = 1'b0;
    end
  end

  // Absolute position and clip against rectangle and frame
  assign px_full = {left[rrpc_pkg::COORD_W-1], left} + POS_W'(col);
  assign py_full = {top[rrpc_pkg::COORD_W-1], top} + POS_W'(row);
  assign in_rect = (col < width) && (row < height);
  assign on_screen = !px_full[POS_W-1] && !py_full[POS_W-1]
                   && (px_full[POS_W-2:0] < (POS_W-1)'(frame_cfg.width))
                   && (py_full[POS_W-2:0] < (POS_W-1)'(frame_cfg.height));

  always_comb begin
    ctl_next.valid       = in_valid;
    ctl_next.keep        = in_rect && on_screen;
    ctl_next.corner_zone = zone;
  end

  // Hold stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl <= ctl_next;
    end
  end

  // Advance stage payload
  always_ff @(posedge clk) begin
    dx       <= dx_next;
    dy       <= dy_next;
    radius_q <= radius;
    px       <= px_full[rrpc_pkg::FRAME_DIM_W-1:0];
    py       <= py_full[rrpc_pkg::FRAME_DIM_W-1:0];
    color_q  <= color;
  end

endmodule

// ===== rtl/core/rrpc_mult.sv =====
// ----------------------------------------------------------------------------
// Rounded rectangle pixel coverage: product stage
// Squares the corner distances and radius, scales the row by the pitch.
// ----------------------------------------------------------------------------
module rrpc_mult #(
  parameter int DIM_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  rrpc_pkg::stage_ctl_t                ctl,
  input  logic [DIM_BITS-2:0]                 dx,
  input  logic [DIM_BITS-2:0]                 dy,
  input  logic [DIM_BITS-2:0]                 radius,
  input  logic [rrpc_pkg::FRAME_DIM_W-1:0]    px,
  input  logic [rrpc_pkg::FRAME_DIM_W-1:0]    py,
  input  logic [rrpc_pkg::COLOR_W-1:0]        color,
  input  logic [rrpc_pkg::PITCH_W-1:0]        pitch,
  output rrpc_pkg::stage_ctl_t                ctl_q,
  output logic [2*(DIM_BITS-1)-1:0]           dx_sq,
  output logic [2*(DIM_BITS-1)-1:0]           dy_sq,
  output logic [2*(DIM_BITS-1)-1:0]           r_sq,
  output logic [rrpc_pkg::ROW_OFF_W-1:0]      row_off,
  output logic [rrpc_pkg::FRAME_DIM_W-1:0]    px_q,
  output logic [rrpc_pkg::COLOR_W-1:0]        color_q
);

  localparam int SQ_W  = 2 * (DIM_BITS - 1);
  localparam int ROW_W = rrpc_pkg::ROW_OFF_W;

  // Hold stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl;
    end
  end

  // Register the four independent products
  always_ff @(posedge clk) begin
    dx_sq   <= SQ_W'(dx) * SQ_W'(dx);
    dy_sq   <= SQ_W'(dy) * SQ_W'(dy);
    r_sq    <= SQ_W'(radius) * SQ_W'(radius);
    row_off <= ROW_W'(py) * ROW_W'(pitch);
    px_q    <= px;
    color_q <= color;
  end

endmodule

// ===== rtl/core/rrpc_resolve.sv =====
// ----------------------------------------------------------------------------
// Rounded rectangle pixel coverage: resolve stage
// Applies the corner cut, forms the byte address and registers the result.
// ----------------------------------------------------------------------------
`include "rounded_rect_pixel_coverage_macros.svh"

module rrpc_resolve #(
  parameter int DIM_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  rrpc_pkg::stage_ctl_t                ctl,
  input  logic [2*(DIM_BITS-1)-1:0]           dx_sq,
  input  logic [2*(DIM_BITS-1)-1:0]           dy_sq,
  input  logic [2*(DIM_BITS-1)-1:0]           r_sq,
  input  logic [rrpc_pkg::ROW_OFF_W-1:0]      row_off,
  input  logic [rrpc_pkg::FRAME_DIM_W-1:0]    px,
  input  logic [rrpc_pkg::COLOR_W-1:0]        color,
  input  logic [rrpc_pkg::ADDR_W-1:0]         base,
  output logic                                done,
  output logic                                pixel_write,
  output logic [rrpc_pkg::ADDR_W-1:0]         pixel_address,
  output logic [rrpc_pkg::COLOR_W-1:0]        pixel_color
);

  localparam int DIST_W = 2 * (DIM_BITS - 1) + 1;
  localparam int ADDR_W = rrpc_pkg::ADDR_W;

  logic [DIST_W-1:0] dist_sq;
  logic              cut;
  logic              write_next;
  logic [ADDR_W-1:0] addr_next;

  // Cut away pixels outside the corner circle
  assign dist_sq    = DIST_W'(dx_sq) + DIST_W'(dy_sq);
  assign cut        = ctl.corner_zone && (dist_sq > DIST_W'(r_sq));
  assign write_next = ctl.valid && ctl.keep && !cut;

  // Byte address: base + row * pitch + 4 * column, wrapping
  assign addr_next = base + ADDR_W'(row_off) + ADDR_W'({px, 2'b00});

  // Hold result strobe and write flag
  always_ff @(posedge clk) begin
    if (rst) begin
      done        <= 1'b0;
      pixel_write <= 1'b0;
    end else begin
      done        <= ctl.valid;
      pixel_write <= write_next;
    end
  end

  // Drop address and color to zero on a skipped pixel
  always_ff @(posedge clk) begin
    pixel_address <= write_next ? addr_next : '0;
    pixel_color   <= write_next ? color : '0;
  end

  `RRPC_ASSERT_IMP(a_write_has_payload_zeroed, !pixel_write,
                   (pixel_address == '0) && (pixel_color == '0))
  `RRPC_ASSERT_NEXT(a_clipped_never_writes, ctl.valid && !ctl.keep, !pixel_write)

endmodule

// ===== rtl/core/rounded_rect_pixel_coverage.sv =====
// ----------------------------------------------------------------------------
// Rounded rectangle pixel coverage: top level
// Decides per pixel whether a filled rounded rectangle writes it, and where.
//
//   channel   signals                                  handshake
//   -------   --------------------------------------   ---------------------
//   item in   rect_*, corner_radius, fill_color,       start high, busy low
//             col_offset, row_offset
//   result    pixel_write, pixel_address, pixel_color  done, one cycle
//   config    cfg_write, cfg_index, cfg_data           cfg_write high
//
// One beat is taken every clock; busy stays low.
// The accepting edge loads the input register; the geometry, product
// (multipliers) and result registers follow in that order, and done
// rises together with the result held in the result register.
// Reset clears the stage valid bits and the frame registers.
// The result side cannot stall, so the pipeline never holds a beat back.
// ----------------------------------------------------------------------------
`include "rounded_rect_pixel_coverage_macros.svh"

module rounded_rect_pixel_coverage #(
  parameter int DIM_BITS = 12
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [rrpc_pkg::COORD_W-1:0]   rect_left,
  input  logic signed [rrpc_pkg::COORD_W-1:0]   rect_top,
  input  logic [DIM_BITS-1:0]                   rect_width,
  input  logic [DIM_BITS-1:0]                   rect_height,
  input  logic [DIM_BITS-2:0]                   corner_radius,
  input  logic [rrpc_pkg::COLOR_W-1:0]          fill_color,
  input  logic [DIM_BITS-1:0]                   col_offset,
  input  logic [DIM_BITS-1:0]                   row_offset,
  input  logic                                  cfg_write,
  input  logic [rrpc_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [rrpc_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic                                  done,
  output logic                                  pixel_write,
  output logic [rrpc_pkg::ADDR_W-1:0]           pixel_address,
  output logic [rrpc_pkg::COLOR_W-1:0]          pixel_color
);

  localparam int SQ_W = 2 * (DIM_BITS - 1);

  rrpc_pkg::frame_cfg_t frame_cfg;
  logic                 accept;

  logic                                in_valid;
  logic [rrpc_pkg::COORD_W-1:0]        in_left;
  logic [rrpc_pkg::COORD_W-1:0]        in_top;
  logic [DIM_BITS-1:0]                 in_width;
  logic [DIM_BITS-1:0]                 in_height;
  logic [DIM_BITS-2:0]                 in_radius;
  logic [rrpc_pkg::COLOR_W-1:0]        in_color;
  logic [DIM_BITS-1:0]                 in_col;
  logic [DIM_BITS-1:0]                 in_row;

  rrpc_pkg::stage_ctl_t                geo_ctl;
  logic [DIM_BITS-2:0]                 geo_dx;
  logic [DIM_BITS-2:0]                 geo_dy;
  logic [DIM_BITS-2:0]                 geo_radius;
  logic [rrpc_pkg::FRAME_DIM_W-1:0]    geo_px;
  logic [rrpc_pkg::FRAME_DIM_W-1:0]    geo_py;
  logic [rrpc_pkg::COLOR_W-1:0]        geo_color;

  rrpc_pkg::stage_ctl_t                mul_ctl;
  logic [SQ_W-1:0]                     mul_dx_sq;
  logic [SQ_W-1:0]                     mul_dy_sq;
  logic [SQ_W-1:0]                     mul_r_sq;
  logic [rrpc_pkg::ROW_OFF_W-1:0]      mul_row_off;
  logic [rrpc_pkg::FRAME_DIM_W-1:0]    mul_px;
  logic [rrpc_pkg::COLOR_W-1:0]        mul_color;

  // Every stage advances each clock, so a beat is always taken
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Frame registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_cfg <= '0;
    end else if (cfg_write) begin
      unique case (rrpc_pkg::cfg_reg_t'(cfg_index))
        rrpc_pkg::CFG_BASE: begin
          frame_cfg.base <= cfg_data[rrpc_pkg::ADDR_W-1:0];
        end
        rrpc_pkg::CFG_PITCH: begin
          frame_cfg.pitch <= cfg_data[rrpc_pkg::PITCH_W-1:0];
        end
        rrpc_pkg::CFG_WIDTH: begin
          frame_cfg.width <= cfg_data[rrpc_pkg::FRAME_DIM_W-1:0];
        end
        rrpc_pkg::CFG_HEIGHT: begin
          frame_cfg.height <= cfg_data[rrpc_pkg::FRAME_DIM_W-1:0];
        end
        default: begin
          frame_cfg <= frame_cfg;
        end
      endcase
    end
  end

  // Input register: valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= accept;
    end
  end

  // Input register: capture the beat
  always_ff @(posedge clk) begin
    if (accept) begin
      in_left   <= rect_left;
      in_top    <= rect_top;
      in_width  <= rect_width;
      in_height <= rect_height;
      in_radius <= corner_radius;
      in_color  <= fill_color;
      in_col    <= col_offset;
      in_row    <= row_offset;
    end
  end

  rrpc_geom #(
    .DIM_BITS (DIM_BITS)
  ) u_geom (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .left      (in_left),
    .top       (in_top),
    .width     (in_width),
    .height    (in_height),
    .radius    (in_radius),
    .col       (in_col),
    .row       (in_row),
    .color     (in_color),
    .frame_cfg (frame_cfg),
    .ctl       (geo_ctl),
    .dx        (geo_dx),
    .dy        (geo_dy),
    .radius_q  (geo_radius),
    .px        (geo_px),
    .py        (geo_py),
    .color_q   (geo_color)
  );

  rrpc_mult #(
    .DIM_BITS (DIM_BITS)
  ) u_mult (
    .clk     (clk),
    .rst     (rst),
    .ctl     (geo_ctl),
    .dx      (geo_dx),
    .dy      (geo_dy),
    .radius  (geo_radius),
    .px      (geo_px),
    .py      (geo_py),
    .color   (geo_color),
    .pitch   (frame_cfg.pitch),
    .ctl_q   (mul_ctl),
    .dx_sq   (mul_dx_sq),
    .dy_sq   (mul_dy_sq),
    .r_sq    (mul_r_sq),
    .row_off (mul_row_off),
    .px_q    (mul_px),
    .color_q (mul_color)
  );

  rrpc_resolve #(
    .DIM_BITS (DIM_BITS)
  ) u_resolve (
    .clk           (clk),
    .rst           (rst),
    .ctl           (mul_ctl),
    .dx_sq         (mul_dx_sq),
    .dy_sq         (mul_dy_sq),
    .r_sq          (mul_r_sq),
    .row_off       (mul_row_off),
    .px            (mul_px),
    .color         (mul_color),
    .base          (frame_cfg.base),
    .done          (done),
    .pixel_write   (pixel_write),
    .pixel_address (pixel_address),
    .pixel_color   (pixel_color)
  );

  `RRPC_ASSERT_LAT(a_beat_gives_result, accept, 4, done)
  `RRPC_ASSERT_LAT(a_no_beat_no_result, !accept, 4, !done)
  `RRPC_ASSERT_IMP(a_write_only_with_done, pixel_write, done)

endmodule

// ===== tb/tb_rounded_rect_pixel_coverage.sv =====
// ----------------------------------------------------------------------------
// Rounded rectangle pixel coverage: testbench
// Drives single-pixel beats (directed corner, clipping and extreme cases,
// then mostly well-formed random rectangles) under several framebuffer
// settings. Predicts each pixel decision and address, and checks every
// result beat in order against the prediction.
// ----------------------------------------------------------------------------
module tb_rounded_rect_pixel_coverage;

  localparam int DIM_BITS = 12;

  typedef struct packed {
    logic [rrpc_pkg::COORD_W-1:0] rect_left;
    logic [rrpc_pkg::COORD_W-1:0] rect_top;
    logic [DIM_BITS-1:0]          rect_width;
    logic [DIM_BITS-1:0]          rect_height;
    logic [DIM_BITS-2:0]          corner_radius;
    logic [rrpc_pkg::COLOR_W-1:0] fill_color;
    logic [DIM_BITS-1:0]          col_offset;
    logic [DIM_BITS-1:0]          row_offset;
  } pixel_item_t;

  typedef struct packed {
    logic                         write;
    logic [rrpc_pkg::ADDR_W-1:0]  address;
    logic [rrpc_pkg::COLOR_W-1:0] color;
  } pixel_result_t;

  logic                                 clk;
  logic                                 rst;
  logic                                 start = 1'b0;
  logic                                 busy;
  logic signed [rrpc_pkg::COORD_W-1:0]  rect_left = '0;
  logic signed [rrpc_pkg::COORD_W-1:0]  rect_top = '0;
  logic [DIM_BITS-1:0]                  rect_width = '0;
  logic [DIM_BITS-1:0]                  rect_height = '0;
  logic [DIM_BITS-2:0]                  corner_radius = '0;
  logic [rrpc_pkg::COLOR_W-1:0]         fill_color = '0;
  logic [DIM_BITS-1:0]                  col_offset = '0;
  logic [DIM_BITS-1:0]                  row_offset = '0;
  logic                                 cfg_write;
  logic [rrpc_pkg::CFG_INDEX_W-1:0]     cfg_index;
  logic [rrpc_pkg::CFG_DATA_W-1:0]      cfg_data;
  logic                                 done;
  logic                                 pixel_write;
  logic [rrpc_pkg::ADDR_W-1:0]          pixel_address;
  logic [rrpc_pkg::COLOR_W-1:0]         pixel_color;

  pixel_item_t          pending_pixels[$];
  pixel_result_t        expected_pixels[$];
  rrpc_pkg::frame_cfg_t frame_regs;
  int                   idle_pct;
  int                   error_count = 0;
  logic                 beat_taken = 1'b0;

  rounded_rect_pixel_coverage #(
    .DIM_BITS(DIM_BITS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .rect_left    (rect_left),
    .rect_top     (rect_top),
    .rect_width   (rect_width),
    .rect_height  (rect_height),
    .corner_radius(corner_radius),
    .fill_color   (fill_color),
    .col_offset   (col_offset),
    .row_offset   (row_offset),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .done         (done),
    .pixel_write  (pixel_write),
    .pixel_address(pixel_address),
    .pixel_color  (pixel_color)
  );

  // Decide coverage and address of one pixel under the given frame registers
  function automatic pixel_result_t predict_pixel(pixel_item_t it,
                                                  rrpc_pkg::frame_cfg_t fb);
    pixel_result_t res;
    longint c, q, w, h, r, px, py, dx, dy;
    logic covered, in_zone;
    logic [63:0] addr;
    c  = longint'(it.col_offset);
    q  = longint'(it.row_offset);
    w  = longint'(it.rect_width);
    h  = longint'(it.rect_height);
    r  = longint'(it.corner_radius);
    px = longint'($signed(it.rect_left)) + c;
    py = longint'($signed(it.rect_top)) + q;
    dx = 0;
    dy = 0;
    covered = (c < w) && (q < h) && (px >= 0) && (py >= 0) &&
              (px < longint'(fb.width)) && (py < longint'(fb.height));
    // Pick the first corner region that matches, in scan order
    in_zone = 1'b1;
    if (c < r && q < r) begin
      dx = r - c;
      dy = r - q;
    end else if (c >= w - r && q < r) begin
      dx = c - (w - r - 1);
      dy = r - q;
    end else if (c < r && q >= h - r) begin
      dx = r - c;
      dy = q - (h - r - 1);
    end else if (c >= w - r && q >= h - r) begin
      dx = c - (w - r - 1);
      dy = q - (h - r - 1);
    end else begin
      in_zone = 1'b0;
    end
    if (covered && in_zone && (dx * dx + dy * dy > r * r)) covered = 1'b0;
    res = '0;
    if (covered) begin
      addr = 64'(fb.base) + 64'(py) * 64'(fb.pitch) + 64'(4 * px);
      res.write   = 1'b1;
      res.address = addr[rrpc_pkg::ADDR_W-1:0];
      res.color   = it.fill_color;
    end
    return res;
  endfunction

  function automatic pixel_item_t make_pixel(int left, int top, int w, int h, int r,
                                             int c, int q, logic [31:0] color);
    pixel_item_t it;
    it.rect_left     = rrpc_pkg::COORD_W'(left);
    it.rect_top      = rrpc_pkg::COORD_W'(top);
    it.rect_width    = DIM_BITS'(w);
    it.rect_height   = DIM_BITS'(h);
    it.corner_radius = (DIM_BITS - 1)'(r);
    it.col_offset    = DIM_BITS'(c);
    it.row_offset    = DIM_BITS'(q);
    it.fill_color    = color;
    return it;
  endfunction

  // Mostly pixels of small rounded rectangles near the screen, some outside
  // the rectangle, some pure noise
  function automatic pixel_item_t random_pixel(int fw, int fh);
    int kind, w, h, r, c, q, x, y;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      return make_pixel($urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom);
    end
    w = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 4095) : $urandom_range(1, 40);
    h = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 4095) : $urandom_range(1, 40);
    case ($urandom_range(0, 9)) inside
      [0:1]:   r = 0;
      2:       r = $urandom_range(0, 2047);
      default: r = $urandom_range(1, ((w < h) ? w : h) / 2 + 2);
    endcase
    if (r > 2047) r = 2047;
    if (kind < 88) begin
      c = $urandom_range(0, w - 1);
      q = $urandom_range(0, h - 1);
    end else begin
      if ($urandom_range(0, 4) == 0) begin
        if ($urandom_range(0, 1)) w = 0;
        else h = 0;
      end
      c = $urandom_range(0, 4095);
      q = $urandom_range(0, 4095);
      if ($urandom_range(0, 1)) c = $urandom_range(w, 4095);
      else q = $urandom_range(h, 4095);
    end
    x = int'($urandom_range(0, fw + 8)) - 4 - c;
    y = int'($urandom_range(0, fh + 8)) - 4 - q;
    return make_pixel(x, y, w, h, r, c, q, $urandom);
  endfunction

  task automatic queue_directed_pixels();
    pending_pixels.push_back(make_pixel(10, 20, 100, 50, 0, 5, 5, 32'h1234_5678));
    pending_pixels.push_back(make_pixel(-32768, 5, 10, 10, 0, 0, 0, 32'hFFFF_FFFF));
    pending_pixels.push_back(make_pixel(32767, 5, 10, 10, 0, 0, 0, 32'h0000_0000));
    pending_pixels.push_back(make_pixel(5, -32768, 10, 10, 0, 0, 0, 32'hFFFF_FFFF));
    pending_pixels.push_back(make_pixel(5, 32767, 10, 10, 0, 0, 0, 32'h0000_0000));
    // empty rectangles
    pending_pixels.push_back(make_pixel(5, 5, 0, 10, 0, 0, 0, 32'h0F0F_0F0F));
    pending_pixels.push_back(make_pixel(5, 5, 10, 0, 0, 0, 0, 32'hF0F0_F0F0));
    // largest rectangle and radius
    pending_pixels.push_back(make_pixel(-2000, -2000, 4095, 4095, 2047, 2047, 2047,
                                        32'hA5A5_A5A5));
    pending_pixels.push_back(make_pixel(0, 0, 4095, 4095, 2047, 0, 0, 32'h5A5A_5A5A));
    // each corner of a small rounded rectangle, cut and kept
    pending_pixels.push_back(make_pixel(100, 100, 20, 20, 5, 2, 2, 32'h0000_0011));
    pending_pixels.push_back(make_pixel(100, 100, 20, 20, 5, 0, 0, 32'h0000_0022));
    pending_pixels.push_back(make_pixel(100, 100, 20, 20, 5, 19, 0, 32'h0000_0033));
    pending_pixels.push_back(make_pixel(100, 100, 20, 20, 5, 0, 19, 32'h0000_0044));
    pending_pixels.push_back(make_pixel(100, 100, 20, 20, 5, 17, 17, 32'h0000_0055));
    pending_pixels.push_back(make_pixel(100, 100, 20, 20, 5, 19, 10, 32'h0000_0066));
    // radius larger than the rectangle
    pending_pixels.push_back(make_pixel(100, 100, 4, 4, 10, 1, 2, 32'h0000_0077));
    // offsets outside the rectangle
    pending_pixels.push_back(make_pixel(100, 100, 20, 20, 5, 20, 3, 32'h0000_0088));
    pending_pixels.push_back(make_pixel(100, 100, 20, 20, 5, 3, 20, 32'h0000_0099));
    pending_pixels.push_back(make_pixel(0, 0, 4095, 4095, 0, 4095, 4095, 32'h0000_00AA));
    // screen edges
    pending_pixels.push_back(make_pixel(635, 475, 8, 8, 0, 4, 4, 32'hDEAD_BEEF));
    pending_pixels.push_back(make_pixel(636, 10, 8, 8, 0, 4, 0, 32'hDEAD_BEEF));
    pending_pixels.push_back(make_pixel(10, 476, 8, 8, 0, 0, 4, 32'hDEAD_BEEF));
    pending_pixels.push_back(make_pixel(-4, -4, 8, 8, 0, 3, 3, 32'hCAFE_F00D));
    pending_pixels.push_back(make_pixel(-4, -4, 8, 8, 0, 4, 4, 32'hCAFE_F00D));
  endtask

  task automatic write_reg(rrpc_pkg::cfg_reg_t idx,
                           logic [rrpc_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
  endtask

  task automatic load_frame(logic [31:0] base, logic [15:0] pitch,
                            logic [12:0] width, logic [12:0] height);
    write_reg(rrpc_pkg::CFG_BASE, base);
    write_reg(rrpc_pkg::CFG_PITCH, {16'b0, pitch});
    write_reg(rrpc_pkg::CFG_WIDTH, {19'b0, width});
    write_reg(rrpc_pkg::CFG_HEIGHT, {19'b0, height});
    @(negedge clk);
    cfg_write <= 1'b0;
    frame_regs.base   = base;
    frame_regs.pitch  = pitch;
    frame_regs.width  = width;
    frame_regs.height = height;
  endtask

  // Hold until every queued beat is sent and every result is back
  task automatic wait_drained();
    while (pending_pixels.size() != 0 || start || expected_pixels.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_phase(logic [31:0] base, logic [15:0] pitch, logic [12:0] width,
                           logic [12:0] height, int idle, int count, bit directed);
    load_frame(base, pitch, width, height);
    idle_pct = idle;
    if (directed) queue_directed_pixels();
    repeat (count) pending_pixels.push_back(random_pixel(int'(width), int'(height)));
    wait_drained();
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Send the next beat once the previous one is taken, idling at random
  always @(negedge clk) begin : drive_pixels
    pixel_item_t nxt;
    logic        go;
    if (!start || beat_taken) begin
      go = 1'b0;
      if (!rst && pending_pixels.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        nxt           = pending_pixels.pop_front();
        go            = 1'b1;
        rect_left     <= nxt.rect_left;
        rect_top      <= nxt.rect_top;
        rect_width    <= nxt.rect_width;
        rect_height   <= nxt.rect_height;
        corner_radius <= nxt.corner_radius;
        fill_color    <= nxt.fill_color;
        col_offset    <= nxt.col_offset;
        row_offset    <= nxt.row_offset;
      end
      start <= go;
    end
  end

  // Check result beats in order, then record the beat accepted at this edge
  always @(posedge clk) begin : check_pixels
    pixel_item_t   cur;
    pixel_result_t exp;
    beat_taken <= start && !busy && !rst;
    if (!rst) begin
      if (done) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: result beat with none expected (write %0b addr %h color %h)",
                   $time, pixel_write, pixel_address, pixel_color);
          error_count++;
        end else begin
          exp = expected_pixels.pop_front();
          if (pixel_write !== exp.write) begin
            $display("%0t: pixel_write expected %0b actual %0b",
                     $time, exp.write, pixel_write);
            error_count++;
          end
          if (pixel_address !== exp.address) begin
            $display("%0t: pixel_address expected %h actual %h",
                     $time, exp.address, pixel_address);
            error_count++;
          end
          if (pixel_color !== exp.color) begin
            $display("%0t: pixel_color expected %h actual %h",
                     $time, exp.color, pixel_color);
            error_count++;
          end
        end
      end
      if (start && !busy) begin
        cur.rect_left     = rect_left;
        cur.rect_top      = rect_top;
        cur.rect_width    = rect_width;
        cur.rect_height   = rect_height;
        cur.corner_radius = corner_radius;
        cur.fill_color    = fill_color;
        cur.col_offset    = col_offset;
        cur.row_offset    = row_offset;
        expected_pixels.push_back(predict_pixel(cur, frame_regs));
      end
    end
  end

  initial begin
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = rrpc_pkg::CFG_BASE;
    cfg_data      = '0;
    frame_regs    = '0;
    idle_pct      = 16;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Reset frame registers clip everything
    queue_directed_pixels();
    wait_drained();

    run_phase(32'h1000_0000, 16'd2560, 13'd640, 13'd480, 16, 400, 1'b1);
    run_phase(32'hFFFF_FF00, 16'hFFFF, 13'd4096, 13'd4096, 16, 400, 1'b0);
    run_phase(32'h0000_0000, 16'h0000, 13'd1, 13'd1, 68, 150, 1'b0);
    run_phase($urandom, 16'($urandom), 13'($urandom_range(0, 4096)),
              13'($urandom_range(0, 4096)), 68, 400, 1'b0);
    run_phase($urandom, 16'($urandom), 13'($urandom_range(1, 4096)),
              13'($urandom_range(1, 4096)), 0, 450, 1'b0);
    run_phase(32'hFFFF_FFFF, 16'h0000, 13'd0, 13'd4096, 0, 150, 1'b0);

    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Bound the run
  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/rrpc_pkg.sv
rtl/core/rrpc_geom.sv
rtl/core/rrpc_mult.sv
rtl/core/rrpc_resolve.sv
rtl/core/rounded_rect_pixel_coverage.sv
tb/tb_rounded_rect_pixel_coverage.sv
